### rtl/sno_pkg.sv
package sno_pkg;

   // fixed internal widths of the normalized datapath
   localparam int UNIT_SHIFT   = 30;
   localparam int SQ_WIDTH     = 31;
   localparam int RAD_WIDTH    = 64;
   localparam int ROOT_WIDTH   = 32;
   localparam int REM_WIDTH    = 36;
   localparam int QUOT_WIDTH   = 31;
   localparam int NUM_WIDTH    = 62;

   // stage counts of each section
   localparam int FRONT_STAGES = 4;
   localparam int SQRT_STAGES  = 32;
   localparam int DIV_STAGES   = QUOT_WIDTH + 1;
   localparam int MID_STAGES   = SQRT_STAGES + DIV_STAGES;

   // per-item control flags that ride along the pipeline
   typedef struct packed {
      logic valid;
      logic degen;
      logic dx_pos;
      logic dx_zero;
      logic dy_pos;
      logic dy_zero;
      logic d_neg;
   } sno_flags_type;

endpackage

### rtl/sno_req_if.sv
interface sno_req_if #(parameter int COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] start_x;
   logic signed [COORD_WIDTH-1:0] start_y;
   logic signed [COORD_WIDTH-1:0] end_x;
   logic signed [COORD_WIDTH-1:0] end_y;
   logic signed [COORD_WIDTH-1:0] offset_distance;

   modport source (output valid, start_x, start_y, end_x, end_y, offset_distance,
                   input ready);
   modport sink (input valid, start_x, start_y, end_x, end_y, offset_distance,
                 output ready);
endinterface

### rtl/sno_rsp_if.sv
interface sno_rsp_if #(parameter int COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] offset_x;
   logic signed [COORD_WIDTH-1:0] offset_y;
   logic                          degenerate;

   modport source (output valid, offset_x, offset_y, degenerate, input ready);
   modport sink (input valid, offset_x, offset_y, degenerate, output ready);
endinterface

### rtl/sno_front.sv
module sno_front
   import sno_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          valid_in,
   input  logic signed [COORD_WIDTH-1:0] start_x,
   input  logic signed [COORD_WIDTH-1:0] start_y,
   input  logic signed [COORD_WIDTH-1:0] end_x,
   input  logic signed [COORD_WIDTH-1:0] end_y,
   input  logic signed [COORD_WIDTH-1:0] offset_distance,
   output sno_flags_type                 flags_out,
   output logic [3*COORD_WIDTH-1:0]      side_out,
   output logic [RAD_WIDTH-1:0]          rad_out,
   output logic [2*SQ_WIDTH-1:0]         mag_out
);

   localparam int AW   = COORD_WIDTH + 1;
   localparam int SMAX = (AW > SQ_WIDTH) ? AW - SQ_WIDTH : 0;
   localparam int SW   = (SMAX > 0) ? $clog2(SMAX + 1) : 1;
   localparam int XW   = 3 * COORD_WIDTH;

   logic signed [AW-1:0]    dx_in, dy_in;
   logic [AW-1:0]           ax_in, ay_in;
   logic [COORD_WIDTH-1:0]  ad_in;
   sno_flags_type           flags_in;

   logic [AW-1:0]           ax_a_ff, ay_a_ff;
   logic [AW-1:0]           mx_a;
   logic [SW-1:0]           shift_in;
   logic [SQ_WIDTH-1:0]     ax_b_in, ay_b_in;
   logic [SQ_WIDTH-1:0]     ax_b_ff, ay_b_ff, ax_c_ff, ay_c_ff, ax_d_ff, ay_d_ff;
   logic [2*SQ_WIDTH-1:0]   sqx_c_ff, sqy_c_ff;
   logic [RAD_WIDTH-1:0]    rad_d_ff;
   sno_flags_type           flags_ff [FRONT_STAGES];
   logic [XW-1:0]           side_ff [FRONT_STAGES];

   // differences, magnitudes and direction flags
   always_comb begin
      dx_in = $signed({end_x[COORD_WIDTH-1], end_x}) -
              $signed({start_x[COORD_WIDTH-1], start_x});
      dy_in = $signed({end_y[COORD_WIDTH-1], end_y}) -
              $signed({start_y[COORD_WIDTH-1], start_y});
      ax_in = dx_in[AW-1] ? AW'(-dx_in) : AW'(dx_in);
      ay_in = dy_in[AW-1] ? AW'(-dy_in) : AW'(dy_in);
      ad_in = offset_distance[COORD_WIDTH-1] ? COORD_WIDTH'(-offset_distance)
                                             : COORD_WIDTH'(offset_distance);
      flags_in.valid   = valid_in;
      flags_in.dx_zero = (dx_in == '0);
      flags_in.dy_zero = (dy_in == '0);
      flags_in.degen   = (dx_in == '0) && (dy_in == '0);
      flags_in.dx_pos  = !dx_in[AW-1] && (dx_in != '0);
      flags_in.dy_pos  = !dy_in[AW-1] && (dy_in != '0);
      flags_in.d_neg   = offset_distance[COORD_WIDTH-1];
   end

   // smallest right shift that brings the larger magnitude under 31 bits
   always_comb begin
      mx_a     = (ax_a_ff > ay_a_ff) ? ax_a_ff : ay_a_ff;
      shift_in = '0;
      for (int k = SMAX; k >= 0; k--) begin
         if (((mx_a >> k) >> SQ_WIDTH) == '0) begin
            shift_in = SW'(k);
         end
      end
      ax_b_in = SQ_WIDTH'(ax_a_ff >> shift_in);
      ay_b_in = SQ_WIDTH'(ay_a_ff >> shift_in);
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (en) begin
         ax_a_ff  <= ax_in;
         ay_a_ff  <= ay_in;
         ax_b_ff  <= ax_b_in;
         ay_b_ff  <= ay_b_in;
         sqx_c_ff <= ax_b_ff * ax_b_ff;
         sqy_c_ff <= ay_b_ff * ay_b_ff;
         ax_c_ff  <= ax_b_ff;
         ay_c_ff  <= ay_b_ff;
         rad_d_ff <= RAD_WIDTH'(sqx_c_ff) + RAD_WIDTH'(sqy_c_ff);
         ax_d_ff  <= ax_c_ff;
         ay_d_ff  <= ay_c_ff;
         side_ff[0] <= {start_x, start_y, ad_in};
         for (int i = 1; i < FRONT_STAGES; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // flags with the valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRONT_STAGES; i++) begin
            flags_ff[i] <= '0;
         end
      end else if (en) begin
         flags_ff[0] <= flags_in;
         for (int i = 1; i < FRONT_STAGES; i++) begin
            flags_ff[i] <= flags_ff[i-1];
         end
      end
   end

   assign flags_out = flags_ff[FRONT_STAGES-1];
   assign side_out  = side_ff[FRONT_STAGES-1];
   assign rad_out   = rad_d_ff;
   assign mag_out   = {ax_d_ff, ay_d_ff};

endmodule

### rtl/sno_sqrt.sv
module sno_sqrt
   import sno_pkg::*;
#(
   parameter int PASS_WIDTH = 62
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [RAD_WIDTH-1:0]   rad_in,
   input  logic [PASS_WIDTH-1:0]  pass_in,
   output logic [ROOT_WIDTH-1:0]  root_out,
   output logic [PASS_WIDTH-1:0]  pass_out
);

   logic [REM_WIDTH-1:0]  rem_ff  [SQRT_STAGES];
   logic [ROOT_WIDTH-1:0] root_ff [SQRT_STAGES];
   logic [RAD_WIDTH-1:0]  rad_ff  [SQRT_STAGES];
   logic [PASS_WIDTH-1:0] pass_ff [SQRT_STAGES];

   // one root bit per stage, two radicand bits shifted in each time
   for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
      logic [REM_WIDTH-1:0]  rem_prev, rem_cat, trial;
      logic [ROOT_WIDTH-1:0] root_prev;
      logic [RAD_WIDTH-1:0]  rad_prev;
      logic [PASS_WIDTH-1:0] pass_prev;

      if (i == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = rad_in;
         assign pass_prev = pass_in;
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
         assign rad_prev  = rad_ff[i-1];
         assign pass_prev = pass_ff[i-1];
      end

      assign rem_cat = {rem_prev[REM_WIDTH-3:0], rad_prev[RAD_WIDTH-1 -: 2]};
      assign trial   = REM_WIDTH'({root_prev, 2'b01});

      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_cat >= trial) begin
               rem_ff[i]  <= rem_cat - trial;
               root_ff[i] <= {root_prev[ROOT_WIDTH-2:0], 1'b1};
            end else begin
               rem_ff[i]  <= rem_cat;
               root_ff[i] <= {root_prev[ROOT_WIDTH-2:0], 1'b0};
            end
            rad_ff[i]  <= rad_prev << 2;
            pass_ff[i] <= pass_prev;
         end
      end
   end

   assign root_out = root_ff[SQRT_STAGES-1];
   assign pass_out = pass_ff[SQRT_STAGES-1];

endmodule

### rtl/sno_div.sv
module sno_div
   import sno_pkg::*;
(
   input  logic                   clock,
   input  logic                   en,
   input  logic [SQ_WIDTH-1:0]    comp_in,
   input  logic [ROOT_WIDTH-1:0]  len_in,
   output logic [QUOT_WIDTH-1:0]  unit_out
);

   localparam int LOW_WIDTH = QUOT_WIDTH;

   logic [NUM_WIDTH-1:0]  num_ff;
   logic [ROOT_WIDTH-1:0] len_p_ff;
   logic [ROOT_WIDTH-1:0] rem_ff  [QUOT_WIDTH];
   logic [ROOT_WIDTH-1:0] len_ff  [QUOT_WIDTH];
   logic [LOW_WIDTH-1:0]  low_ff  [QUOT_WIDTH];
   logic [QUOT_WIDTH-1:0] quot_ff [QUOT_WIDTH];

   // rounded numerator: comp * 2^30 + len / 2
   always_ff @(posedge clock) begin
      if (en) begin
         num_ff   <= {comp_in, UNIT_SHIFT'(0)} + NUM_WIDTH'(len_in >> 1);
         len_p_ff <= len_in;
      end
   end

   // restoring division, one quotient bit per stage; the upper numerator
   // bits are already below the divisor since the quotient fits 31 bits
   for (genvar i = 0; i < QUOT_WIDTH; i++) begin : g_stage
      logic [ROOT_WIDTH-1:0] rem_prev, len_prev;
      logic [LOW_WIDTH-1:0]  low_prev;
      logic [QUOT_WIDTH-1:0] quot_prev;
      logic [ROOT_WIDTH:0]   trial;
      logic                  ge;

      if (i == 0) begin : g_first
         assign rem_prev  = ROOT_WIDTH'(num_ff[NUM_WIDTH-1:LOW_WIDTH]);
         assign low_prev  = num_ff[LOW_WIDTH-1:0];
         assign len_prev  = len_p_ff;
         assign quot_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign low_prev  = low_ff[i-1];
         assign len_prev  = len_ff[i-1];
         assign quot_prev = quot_ff[i-1];
      end

      assign trial = {rem_prev, low_prev[LOW_WIDTH-1]};
      assign ge    = (trial >= {1'b0, len_prev});

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= ge ? ROOT_WIDTH'(trial - {1'b0, len_prev})
                             : ROOT_WIDTH'(trial);
            quot_ff[i] <= {quot_prev[QUOT_WIDTH-2:0], ge};
            low_ff[i]  <= low_prev << 1;
            len_ff[i]  <= len_prev;
         end
      end
   end

   assign unit_out = quot_ff[QUOT_WIDTH-1];

endmodule

### rtl/sno_back.sv
module sno_back
   import sno_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sno_flags_type          flags_in,
   input  logic [COORD_WIDTH-1:0] sx_in,
   input  logic [COORD_WIDTH-1:0] sy_in,
   input  logic [COORD_WIDTH-1:0] ad_in,
   input  logic [QUOT_WIDTH-1:0]  ux_in,
   input  logic [QUOT_WIDTH-1:0]  uy_in,
   output logic                   pipe_en,
   sno_rsp_if.source              rsp_chan
);

   localparam int LO   = COORD_WIDTH / 2;
   localparam int HI   = COORD_WIDTH - LO;
   localparam int SUMW = COORD_WIDTH + QUOT_WIDTH + 1;
   localparam int MW   = SUMW - UNIT_SHIFT;
   localparam int RW   = COORD_WIDTH + 3;

   logic [HI+QUOT_WIDTH-1:0] phx_ff, phy_ff;
   logic [LO+QUOT_WIDTH-1:0] plx_ff, ply_ff;
   logic [COORD_WIDTH-1:0]   sx_b1_ff, sy_b1_ff, sx_b2_ff, sy_b2_ff;
   sno_flags_type            flags_b1_ff, flags_b2_ff;
   logic [SUMW-1:0]          sumx_in, sumy_in;
   logic [MW-1:0]            magx_ff, magy_ff;
   logic signed [RW-1:0]     rx_in, ry_in;
   logic [COORD_WIDTH-1:0]   ox_in, oy_in;
   logic                     out_valid_ff;
   logic [COORD_WIDTH-1:0]   ox_ff, oy_ff;
   logic                     degen_ff;

   // pipeline moves unless a finished item is blocked behind a held result
   assign pipe_en = !flags_b2_ff.valid || !out_valid_ff || rsp_chan.ready;

   // split products of distance and unit components
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         phx_ff   <= ad_in[COORD_WIDTH-1:LO] * uy_in;
         plx_ff   <= ad_in[LO-1:0] * uy_in;
         phy_ff   <= ad_in[COORD_WIDTH-1:LO] * ux_in;
         ply_ff   <= ad_in[LO-1:0] * ux_in;
         sx_b1_ff <= sx_in;
         sy_b1_ff <= sy_in;
         magx_ff  <= sumx_in[SUMW-1:UNIT_SHIFT];
         magy_ff  <= sumy_in[SUMW-1:UNIT_SHIFT];
         sx_b2_ff <= sx_b1_ff;
         sy_b2_ff <= sy_b1_ff;
      end
   end

   // recombine and round to nearest
   always_comb begin
      sumx_in = SUMW'({phx_ff, LO'(0)}) + SUMW'(plx_ff) + SUMW'(1 << (UNIT_SHIFT - 1));
      sumy_in = SUMW'({phy_ff, LO'(0)}) + SUMW'(ply_ff) + SUMW'(1 << (UNIT_SHIFT - 1));
   end

   // apply signs and saturate
   always_comb begin
      rx_in = RW'($signed(sx_b2_ff));
      ry_in = RW'($signed(sy_b2_ff));
      if (!flags_b2_ff.dy_zero) begin
         if (flags_b2_ff.dy_pos != flags_b2_ff.d_neg) begin
            rx_in = rx_in - $signed(RW'(magx_ff));
         end else begin
            rx_in = rx_in + $signed(RW'(magx_ff));
         end
      end
      if (!flags_b2_ff.dx_zero) begin
         if (flags_b2_ff.dx_pos != flags_b2_ff.d_neg) begin
            ry_in = ry_in + $signed(RW'(magy_ff));
         end else begin
            ry_in = ry_in - $signed(RW'(magy_ff));
         end
      end
      if (rx_in[RW-1:COORD_WIDTH-1] != '0 && rx_in[RW-1:COORD_WIDTH-1] != '1) begin
         ox_in = rx_in[RW-1] ? {1'b1, (COORD_WIDTH-1)'(0)} : {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end else begin
         ox_in = rx_in[COORD_WIDTH-1:0];
      end
      if (ry_in[RW-1:COORD_WIDTH-1] != '0 && ry_in[RW-1:COORD_WIDTH-1] != '1) begin
         oy_in = ry_in[RW-1] ? {1'b1, (COORD_WIDTH-1)'(0)} : {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end else begin
         oy_in = ry_in[COORD_WIDTH-1:0];
      end
   end

   // flag stages
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_b1_ff <= '0;
         flags_b2_ff <= '0;
      end else if (pipe_en) begin
         flags_b1_ff <= flags_in;
         flags_b2_ff <= flags_b1_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_chan.ready) begin
         out_valid_ff <= flags_b2_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_chan.ready) begin
         ox_ff    <= ox_in;
         oy_ff    <= oy_in;
         degen_ff <= flags_b2_ff.degen;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.offset_x   = $signed(ox_ff);
   assign rsp_chan.offset_y   = $signed(oy_ff);
   assign rsp_chan.degenerate = degen_ff;

endmodule

### rtl/segment_normal_offset_top.sv
// pipeline: 4 front, 32 square root, 32 divide, 2 scale stages and the
// output register between request and result
// throughput: one request per cycle; the whole pipeline holds only when
// a finished item meets a result that is not taken
// reset: synchronous, active high, clears all valid bits
module segment_normal_offset_top
   import sno_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   sno_req_if.sink   req_chan,
   sno_rsp_if.source rsp_chan
);

   localparam int XW = 3 * COORD_WIDTH;

   logic                   pipe_en;
   sno_flags_type          flags_f;
   logic [XW-1:0]          side_f;
   logic [RAD_WIDTH-1:0]   rad_f;
   logic [2*SQ_WIDTH-1:0]  mag_f, mag_s;
   logic [ROOT_WIDTH-1:0]  len_s;
   logic [QUOT_WIDTH-1:0]  ux, uy;
   sno_flags_type          flags_ff [MID_STAGES];
   logic [XW-1:0]          side_ff  [MID_STAGES];
   logic [XW-1:0]          side_m;

   assign req_chan.ready = pipe_en;

   sno_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock           (clock),
      .reset           (reset),
      .en              (pipe_en),
      .valid_in        (req_chan.valid && pipe_en),
      .start_x         (req_chan.start_x),
      .start_y         (req_chan.start_y),
      .end_x           (req_chan.end_x),
      .end_y           (req_chan.end_y),
      .offset_distance (req_chan.offset_distance),
      .flags_out       (flags_f),
      .side_out        (side_f),
      .rad_out         (rad_f),
      .mag_out         (mag_f)
   );

   sno_sqrt #(.PASS_WIDTH(2 * SQ_WIDTH)) u_sqrt (
      .clock    (clock),
      .en       (pipe_en),
      .rad_in   (rad_f),
      .pass_in  (mag_f),
      .root_out (len_s),
      .pass_out (mag_s)
   );

   sno_div u_div_x (
      .clock    (clock),
      .en       (pipe_en),
      .comp_in  (mag_s[2*SQ_WIDTH-1:SQ_WIDTH]),
      .len_in   (len_s),
      .unit_out (ux)
   );

   sno_div u_div_y (
      .clock    (clock),
      .en       (pipe_en),
      .comp_in  (mag_s[SQ_WIDTH-1:0]),
      .len_in   (len_s),
      .unit_out (uy)
   );

   // start point, distance and flags wait out the root and divide
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         side_ff[0] <= side_f;
         for (int i = 1; i < MID_STAGES; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MID_STAGES; i++) begin
            flags_ff[i] <= '0;
         end
      end else if (pipe_en) begin
         flags_ff[0] <= flags_f;
         for (int i = 1; i < MID_STAGES; i++) begin
            flags_ff[i] <= flags_ff[i-1];
         end
      end
   end

   assign side_m = side_ff[MID_STAGES-1];

   sno_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock    (clock),
      .reset    (reset),
      .flags_in (flags_ff[MID_STAGES-1]),
      .sx_in    (side_m[XW-1 -: COORD_WIDTH]),
      .sy_in    (side_m[2*COORD_WIDTH-1 -: COORD_WIDTH]),
      .ad_in    (side_m[COORD_WIDTH-1:0]),
      .ux_in    (ux),
      .uy_in    (uy),
      .pipe_en  (pipe_en),
      .rsp_chan (rsp_chan)
   );

endmodule

### rtl/sno_checker.sv
module sno_checker #(
   parameter int COORD_WIDTH = 32
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [COORD_WIDTH-1:0] rsp_offset_x,
   input logic [COORD_WIDTH-1:0] rsp_offset_y,
   input logic                   rsp_degenerate
);

   // a held result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a held result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
      $stable(rsp_offset_x) && $stable(rsp_offset_y) && $stable(rsp_degenerate))
      else $error("result changed while stalled");

   // with the output slot free or draining, requests are taken
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("request stalled with free output");

   // after reset no result is offered
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind segment_normal_offset_top sno_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sno_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_offset_x   (rsp_chan.offset_x),
   .rsp_offset_y   (rsp_chan.offset_y),
   .rsp_degenerate (rsp_chan.degenerate)
);

### dv/tb_segment_normal_offset_top.sv
module tb_segment_normal_offset_top;
   import sno_pkg::*;

   localparam int CW = 32;
   localparam int LATENCY = 71;
   localparam int N_RANDOM = 1230;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [CW-1:0] sx;
      logic signed [CW-1:0] sy;
      logic signed [CW-1:0] ex;
      logic signed [CW-1:0] ey;
      logic signed [CW-1:0] offs;
   } segment_type;

   typedef struct packed {
      logic signed [CW-1:0] ox;
      logic signed [CW-1:0] oy;
      logic                 degen;
   } offset_point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sno_req_if #(.COORD_WIDTH(CW)) req_chan ();
   sno_rsp_if #(.COORD_WIDTH(CW)) rsp_chan ();

   segment_normal_offset_top #(.COORD_WIDTH(CW)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   segment_type      pending_segments[$];
   offset_point_type expected_points[$];
   int               mismatch_count = 0;
   longint           cycle_count = 0;
   bit               stimulus_done = 0;
   bit               hold_sender = 0;
   bit               calm_stretch = 0;
   bit               req_taken = 0;

   // clock generation
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // round(mag_in * u / 2^30) with ties away from zero
   function automatic longint unsigned scale_by_unit(longint unsigned mag_in,
                                                     longint unsigned u);
      logic [127:0] p;
      p = 128'(mag_in) * 128'(u) + (128'd1 << (UNIT_SHIFT - 1));
      return 64'(p >> UNIT_SHIFT);
   endfunction

   function automatic longint clamp_coord(longint v);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (CW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // computes the offset start point of a segment
   function automatic offset_point_type offset_start_point(segment_type seg);
      offset_point_type r;
      longint sx, sy, dxv, dyv, d, rx, ry;
      longint unsigned ax, ay, mx, len, ux, uy, ad, offx, offy;
      int s;
      bit dneg;
      sx = seg.sx; sy = seg.sy; d = seg.offs;
      dxv = longint'(seg.ex) - sx;
      dyv = longint'(seg.ey) - sy;
      rx = sx; ry = sy;
      r.degen = 1'b0;
      if (dxv == 0 && dyv == 0) begin
         r.degen = 1'b1;
      end else begin
         ax = dxv < 0 ? -dxv : dxv;
         ay = dyv < 0 ? -dyv : dyv;
         mx = ax > ay ? ax : ay;
         s = 0;
         while ((mx >> s) >= (64'd1 << 31)) s++;
         ax >>= s;
         ay >>= s;
         len = int_sqrt(ax * ax + ay * ay);
         ux = ((ax << UNIT_SHIFT) + (len >> 1)) / len;
         uy = ((ay << UNIT_SHIFT) + (len >> 1)) / len;
         dneg = d < 0;
         ad = dneg ? -d : d;
         offx = scale_by_unit(ad, uy);
         offy = scale_by_unit(ad, ux);
         if ((dyv > 0) != dneg) rx = sx - longint'(offx);
         else rx = sx + longint'(offx);
         if (dyv == 0) rx = sx;
         if ((dxv > 0) != dneg) ry = sy + longint'(offy);
         else ry = sy - longint'(offy);
         if (dxv == 0) ry = sy;
         rx = clamp_coord(rx);
         ry = clamp_coord(ry);
      end
      r.ox = rx[CW-1:0];
      r.oy = ry[CW-1:0];
      return r;
   endfunction

   function automatic logic [CW-1:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return {1'b0, {(CW-1){1'b1}}};
         1: return {1'b1, {(CW-1){1'b0}}};
         2: return CW'($urandom_range(0, 64)) - CW'(32);
         3: return CW'($urandom_range(0, 1 << 20)) << 8;
         default: return CW'($urandom);
      endcase
   endfunction

   function automatic segment_type random_segment();
      segment_type seg;
      seg.sx = pick_coord();
      seg.sy = pick_coord();
      case ($urandom_range(0, 9))
         0: begin seg.ex = seg.sx; seg.ey = seg.sy; end
         1: begin seg.ex = seg.sx; seg.ey = pick_coord(); end
         2: begin seg.ex = pick_coord(); seg.ey = seg.sy; end
         3: begin
            seg.ex = seg.sx + CW'($urandom_range(0, 2000)) - CW'(1000);
            seg.ey = seg.sy + CW'($urandom_range(0, 2000)) - CW'(1000);
         end
         default: begin seg.ex = pick_coord(); seg.ey = pick_coord(); end
      endcase
      seg.offs = ($urandom_range(0, 15) == 0) ? '0 : pick_coord();
      return seg;
   endfunction

   function automatic segment_type make_segment(logic [CW-1:0] sx, logic [CW-1:0] sy,
                                                logic [CW-1:0] ex, logic [CW-1:0] ey,
                                                logic [CW-1:0] offs);
      segment_type seg;
      seg.sx = sx; seg.sy = sy; seg.ex = ex; seg.ey = ey; seg.offs = offs;
      return seg;
   endfunction

   task automatic report_mismatch(string field, logic [CW-1:0] got, logic [CW-1:0] want);
      mismatch_count++;
      $display("mismatch on %s: got %h expected %h", field, got, want);
   endtask

   // stimulus: directed corner cases, then random segments
   initial begin
      logic [CW-1:0] maxv, minv, one;
      maxv = {1'b0, {(CW-1){1'b1}}};
      minv = {1'b1, {(CW-1){1'b0}}};
      one = CW'(32'h0001_0000);
      pending_segments.push_back(make_segment(0, 0, one, 0, one));
      pending_segments.push_back(make_segment(0, 0, 0, one, one));
      pending_segments.push_back(make_segment(0, 0, -one, 0, one));
      pending_segments.push_back(make_segment(0, 0, 0, -one, -one));
      pending_segments.push_back(make_segment(one, one, one, one, one));
      pending_segments.push_back(make_segment(maxv, minv, maxv, minv, maxv));
      pending_segments.push_back(make_segment(5, 7, 100, -40, 0));
      pending_segments.push_back(make_segment(minv, minv, maxv, maxv, maxv));
      pending_segments.push_back(make_segment(maxv, maxv, minv, minv, minv));
      pending_segments.push_back(make_segment(minv, 0, maxv, 0, maxv));
      pending_segments.push_back(make_segment(0, maxv, 0, minv, minv));
      pending_segments.push_back(make_segment(maxv, maxv, maxv - 1, maxv, maxv));
      pending_segments.push_back(make_segment(minv, minv, minv, minv + 1, maxv));
      pending_segments.push_back(make_segment(0, 0, 3, 4, one));
      pending_segments.push_back(make_segment(0, 0, -3, 4, -one));
      pending_segments.push_back(make_segment(1, 1, 2, 2, 1));
      pending_segments.push_back(make_segment(0, 0, 1, 1, 3));
      pending_segments.push_back(make_segment(0, 0, 1, 2, minv));
      pending_segments.push_back(make_segment(maxv, 0, minv, 1, minv));
      pending_segments.push_back(make_segment(0, 0, maxv, maxv, -1));
      for (int i = 0; i < N_RANDOM; i++) begin
         pending_segments.push_back(random_segment());
         if (i == 600) begin
            // hold the sender until the pipeline drains
            wait (pending_segments.size() == 1);
            hold_sender = 1;
            wait (expected_points.size() == 0);
            hold_sender = 0;
         end
      end
      stimulus_done = 1;
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         // a request stays put until it is taken
         if (!req_chan.valid || req_taken) begin
            if (pending_segments.size() > 0 && !hold_sender &&
                (calm_stretch || $urandom_range(0, 99) >= 37)) begin
               segment_type seg;
               seg = pending_segments[0];
               req_chan.valid <= 1'b1;
               req_chan.start_x <= seg.sx;
               req_chan.start_y <= seg.sy;
               req_chan.end_x <= seg.ex;
               req_chan.end_y <= seg.ey;
               req_chan.offset_distance <= seg.offs;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
         rsp_chan.ready <= calm_stretch || ($urandom_range(0, 99) >= 37);
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.start_x = '0;
      req_chan.start_y = '0;
      req_chan.end_x = '0;
      req_chan.end_y = '0;
      req_chan.offset_distance = '0;
      rsp_chan.ready = 1'b0;
   end

   // monitor: requests feed the predictor, responses are checked
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      calm_stretch <= (cycle_count % 2000) >= 1400;
      req_taken <= !reset && req_chan.valid && req_chan.ready;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            segment_type seg;
            seg.sx = req_chan.start_x;
            seg.sy = req_chan.start_y;
            seg.ex = req_chan.end_x;
            seg.ey = req_chan.end_y;
            seg.offs = req_chan.offset_distance;
            expected_points.push_back(offset_start_point(seg));
            void'(pending_segments.pop_front());
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_points.size() == 0) begin
               report_mismatch("unexpected response", rsp_chan.offset_x, '0);
            end else begin
               offset_point_type want;
               want = expected_points.pop_front();
               if (rsp_chan.offset_x !== want.ox)
                  report_mismatch("offset_x", rsp_chan.offset_x, want.ox);
               if (rsp_chan.offset_y !== want.oy)
                  report_mismatch("offset_y", rsp_chan.offset_y, want.oy);
               if (rsp_chan.degenerate !== want.degen)
                  report_mismatch("degenerate", rsp_chan.degenerate, want.degen);
            end
         end
      end
   end

   // reset, drain and final verdict
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done && pending_segments.size() == 0 && expected_points.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (mismatch_count == 0 && expected_points.size() == 0)
         $display("segment_normal_offset_top regression: pass");
      else
         $display("segment_normal_offset_top regression: fail");
      $finish;
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("segment_normal_offset_top regression: fail");
         $finish;
      end
   end

endmodule
